>>> design/cpbc_pkg.sv
package cpbc_pkg;

	localparam int ACC_W     = 58;
	localparam int PROD_W    = 57;
	localparam int OPND_W    = 41;
	localparam int HALF_W    = 25;
	localparam int FRAC_W    = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [39:0] S40_MAX = 40'sh7F_FFFF_FFFF;
	localparam logic signed [39:0] S40_MIN = 40'sh80_0000_0000;

	localparam logic signed [31:0] RST_INNER_P = 32'sd655360;
	localparam logic signed [31:0] RST_INNER_I = 32'sd19661;
	localparam logic signed [31:0] RST_INNER_D = 32'sd65536;
	localparam logic signed [31:0] RST_OUTER_P = 32'sd2490;
	localparam logic signed [31:0] RST_OUTER_I = 32'sd5;
	localparam logic signed [31:0] RST_OUTER_D = 32'sd655;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INNER_P = 3'd0,
		REG_INNER_I = 3'd1,
		REG_INNER_D = 3'd2,
		REG_OUTER_P = 3'd3,
		REG_OUTER_I = 3'd4,
		REG_OUTER_D = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic              command_valid;
		logic signed [31:0] command_linear;
		logic signed [31:0] command_angular;
		logic signed [31:0] measured_pitch;
	} tick_t;

	typedef struct packed {
		logic signed [31:0] drive_linear;
		logic signed [31:0] drive_angular;
	} drive_t;

	typedef struct packed {
		logic signed [31:0] inner_prop_gain;
		logic signed [31:0] inner_integ_gain_dt;
		logic signed [31:0] inner_deriv_gain_dt;
		logic signed [31:0] outer_prop_gain;
		logic signed [31:0] outer_integ_gain_dt;
		logic signed [31:0] outer_deriv_gain_dt;
	} gains_t;

	typedef enum logic [3:0] {
		ST_WAIT,
		ST_ERR,
		ST_INTEG,
		ST_P_HI,
		ST_P_LO,
		ST_I_HI,
		ST_I_LO,
		ST_D_HI,
		ST_D_LO,
		ST_LOOP_END,
		ST_DRIVE,
		ST_EMIT
	} step_t;

	typedef enum logic [1:0] {
		SEQ_NEXT,
		SEQ_WAIT_IN,
		SEQ_LOOP,
		SEQ_EMIT
	} seq_op_t;

	typedef enum logic [1:0] {
		TERM_P,
		TERM_I,
		TERM_D
	} term_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_CLR,
		ACC_FULL,
		ACC_SHR
	} acc_op_t;

	typedef struct packed {
		seq_op_t seq;
		step_t   target;
		logic    err_ld;
		logic    integ_ld;
		logic    mul_en;
		term_t   term;
		logic    mul_lo;
		acc_op_t acc;
		logic    drive_ld;
	} uword_t;

	typedef struct packed {
		uword_t uw;
		logic   loop_inner;
		logic   in_ready;
		logic   in_fire;
		logic   emit_fire;
	} ctl_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
	} stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [31:0] r;
		if (v[ACC_W-1:31] == '0 || v[ACC_W-1:31] == '1)
			r = v[31:0];
		else
			r = v[ACC_W-1] ? S32_MIN : S32_MAX;
		return r;
	endfunction

	function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
		logic signed [39:0] r;
		if (v[40] == v[39])
			r = v[39:0];
		else
			r = v[40] ? S40_MIN : S40_MAX;
		return r;
	endfunction

	// Control store: one loop body, run once for the outer and once for the inner PID
	function automatic uword_t ucode(input step_t step);
		uword_t w;
		w = '0;
		unique case (step)
			ST_WAIT: begin
				w.seq = SEQ_WAIT_IN;
			end
			ST_ERR: begin
				w.err_ld = 1'b1;
			end
			ST_INTEG: begin
				w.integ_ld = 1'b1;
				w.acc      = ACC_CLR;
			end
			ST_P_HI: begin
				w.mul_en = 1'b1;
				w.term   = TERM_P;
			end
			ST_P_LO: begin
				w.mul_en = 1'b1;
				w.term   = TERM_P;
				w.mul_lo = 1'b1;
				w.acc    = ACC_FULL;
			end
			ST_I_HI: begin
				w.mul_en = 1'b1;
				w.term   = TERM_I;
				w.acc    = ACC_SHR;
			end
			ST_I_LO: begin
				w.mul_en = 1'b1;
				w.term   = TERM_I;
				w.mul_lo = 1'b1;
				w.acc    = ACC_FULL;
			end
			ST_D_HI: begin
				w.mul_en = 1'b1;
				w.term   = TERM_D;
				w.acc    = ACC_SHR;
			end
			ST_D_LO: begin
				w.mul_en = 1'b1;
				w.term   = TERM_D;
				w.mul_lo = 1'b1;
				w.acc    = ACC_FULL;
			end
			ST_LOOP_END: begin
				w.seq    = SEQ_LOOP;
				w.target = ST_ERR;
				w.acc    = ACC_SHR;
			end
			ST_DRIVE: begin
				w.drive_ld = 1'b1;
			end
			ST_EMIT: begin
				w.seq    = SEQ_EMIT;
				w.target = ST_WAIT;
			end
			default: begin
				w.seq    = SEQ_EMIT;
				w.target = ST_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

>>> design/cpbc_sequencer.sv
module cpbc_sequencer import cpbc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctl_t  ctl
);

	step_t  step_q, step_d;
	step_t  step_inc;
	logic   loop_inner_q, loop_inner_d;
	uword_t uw;

	assign uw       = ucode(step_q);
	assign step_inc = step_t'(step_q + 1'b1);

	always_comb begin
		step_d       = step_q;
		loop_inner_d = loop_inner_q;
		unique case (uw.seq)
			SEQ_NEXT: begin
				step_d = step_inc;
			end
			SEQ_WAIT_IN: begin
				if (stat.in_valid) begin
					step_d       = step_inc;
					loop_inner_d = 1'b0;
				end
			end
			SEQ_LOOP: begin
				// run the body a second time for the inner loop
				if (loop_inner_q) begin
					step_d = step_inc;
				end else begin
					step_d       = uw.target;
					loop_inner_d = 1'b1;
				end
			end
			SEQ_EMIT: begin
				if (stat.out_free)
					step_d = uw.target;
			end
			default: begin
				step_d = ST_WAIT;
			end
		endcase
	end

	always_comb begin
		ctl.uw         = uw;
		ctl.loop_inner = loop_inner_q;
		ctl.in_ready   = (uw.seq == SEQ_WAIT_IN);
		ctl.in_fire    = (uw.seq == SEQ_WAIT_IN) && stat.in_valid;
		ctl.emit_fire  = (uw.seq == SEQ_EMIT) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= ST_WAIT;
			loop_inner_q <= 1'b0;
		end else begin
			step_q       <= step_d;
			loop_inner_q <= loop_inner_d;
		end
	end

endmodule

>>> design/cpbc_datapath.sv
module cpbc_datapath import cpbc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  ctl_t   ctl,
	input  tick_t  tick,
	input  gains_t gains,
	output drive_t result
);

	logic signed [31:0]        lin_q, ang_q, pitch_q;
	logic signed [31:0]        err_q;
	logic signed [32:0]        diff_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;

	logic signed [39:0]        osum_q, isum_q;
	logic signed [31:0]        olast_q, ilast_q, last_drive_q;

	logic signed [31:0]        acc_sat;
	logic signed [31:0]        err_x;
	logic signed [32:0]        err_y;
	logic signed [33:0]        err_sum;
	logic signed [31:0]        err_new;
	logic signed [39:0]        sum_cur, sum_new;
	logic signed [31:0]        last_cur;
	logic signed [32:0]        diff_new;
	logic signed [OPND_W-1:0]  opnd;
	logic signed [31:0]        mul_a;
	logic signed [HALF_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]  product;
	logic signed [ACC_W-1:0]   acc_add;

	assign acc_sat = sat32(acc_q);

	// outer error: command plus last drive; inner error: setpoint minus pitch
	assign err_x   = ctl.loop_inner ? acc_sat : lin_q;
	assign err_y   = ctl.loop_inner ? -(33'(pitch_q)) : 33'(last_drive_q);
	assign err_sum = 34'(err_x) + 34'(err_y);
	assign err_new = sat32(ACC_W'(err_sum));

	assign sum_cur  = ctl.loop_inner ? isum_q : osum_q;
	assign last_cur = ctl.loop_inner ? ilast_q : olast_q;
	assign sum_new  = sat40(41'(sum_cur) + 41'(err_q));
	assign diff_new = 33'(err_q) - 33'(last_cur);

	always_comb begin
		case (ctl.uw.term)
			TERM_P:  opnd = OPND_W'(err_q);
			TERM_I:  opnd = OPND_W'(sum_cur);
			TERM_D:  opnd = OPND_W'(diff_q);
			default: opnd = '0;
		endcase
	end

	always_comb begin
		case (ctl.uw.term)
			TERM_P:  mul_a = ctl.loop_inner ? gains.inner_prop_gain : gains.outer_prop_gain;
			TERM_I:  mul_a = ctl.loop_inner ? gains.inner_integ_gain_dt
			                                : gains.outer_integ_gain_dt;
			TERM_D:  mul_a = ctl.loop_inner ? gains.inner_deriv_gain_dt
			                                : gains.outer_deriv_gain_dt;
			default: mul_a = '0;
		endcase
	end

	// split the operand: signed upper part, unsigned low 16 bits
	assign mul_b   = ctl.uw.mul_lo ? $signed({{(HALF_W-FRAC_W){1'b0}}, opnd[FRAC_W-1:0]})
	                               : $signed(opnd[OPND_W-1:FRAC_W]);
	assign product = mul_a * mul_b;

	assign acc_add = acc_q + ((ctl.uw.acc == ACC_SHR)
		? ACC_W'($signed(prod_q[PROD_W-1:FRAC_W]))
		: ACC_W'(prod_q));

	always_ff @(posedge clk) begin
		if (ctl.in_fire) begin
			lin_q   <= tick.command_valid ? tick.command_linear : '0;
			ang_q   <= tick.command_valid ? tick.command_angular : '0;
			pitch_q <= tick.measured_pitch;
		end
		if (ctl.uw.err_ld)
			err_q <= err_new;
		if (ctl.uw.integ_ld)
			diff_q <= diff_new;
		if (ctl.uw.mul_en)
			prod_q <= product;
		case (ctl.uw.acc) inside
			ACC_CLR:           acc_q <= '0;
			ACC_FULL, ACC_SHR: acc_q <= acc_add;
			default:           acc_q <= acc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			osum_q       <= '0;
			isum_q       <= '0;
			olast_q      <= '0;
			ilast_q      <= '0;
			last_drive_q <= '0;
		end else begin
			if (ctl.uw.integ_ld) begin
				if (ctl.loop_inner) begin
					isum_q  <= sum_new;
					ilast_q <= err_q;
				end else begin
					osum_q  <= sum_new;
					olast_q <= err_q;
				end
			end
			if (ctl.uw.drive_ld)
				last_drive_q <= acc_sat;
		end
	end

	assign result.drive_linear  = (last_drive_q == S32_MIN) ? S32_MAX : -last_drive_q;
	assign result.drive_angular = ang_q;

endmodule

>>> design/cascaded_pid_balance_controller.sv
// Channel  Signals                          Direction  Payload
// tick     tick_valid, tick_ready, tick     in         tick_t: command and measured pitch
// drive    drive_valid, drive_ready, drive  out        drive_t: linear and angular drive
// cfg      cfg_we, cfg_idx, cfg_wdata       in         gain register write, no read-back
//
// A tick is taken only at the wait step, and tick_ready stays low from a transfer until
// the result is loaded. The control store runs a nine-step PID body twice (outer, then
// inner), sharing one 32x25 multiplier for six half products per loop, plus two steps to
// form and register the drive. Reset clears the sequencer, integrators, last errors and
// last drive and loads the gain defaults. A result waits in the output register; the
// sequencer stalls at its final step only if the previous result is still untaken.
module cascaded_pid_balance_controller import cpbc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick_valid,
	output logic                 tick_ready,
	input  tick_t                tick,
	output logic                 drive_valid,
	input  logic                 drive_ready,
	output drive_t               drive,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [31:0]          cfg_wdata
);

	gains_t gains_q;
	drive_t drive_q;
	logic   drive_valid_q;
	stat_t  stat;
	ctl_t   ctl;
	drive_t result;

	assign stat.in_valid = tick_valid;
	assign stat.out_free = !drive_valid_q || drive_ready;

	cpbc_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	cpbc_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.tick   (tick),
		.gains  (gains_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.inner_prop_gain     <= RST_INNER_P;
			gains_q.inner_integ_gain_dt <= RST_INNER_I;
			gains_q.inner_deriv_gain_dt <= RST_INNER_D;
			gains_q.outer_prop_gain     <= RST_OUTER_P;
			gains_q.outer_integ_gain_dt <= RST_OUTER_I;
			gains_q.outer_deriv_gain_dt <= RST_OUTER_D;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_INNER_P: gains_q.inner_prop_gain     <= cfg_wdata;
				REG_INNER_I: gains_q.inner_integ_gain_dt <= cfg_wdata;
				REG_INNER_D: gains_q.inner_deriv_gain_dt <= cfg_wdata;
				REG_OUTER_P: gains_q.outer_prop_gain     <= cfg_wdata;
				REG_OUTER_I: gains_q.outer_integ_gain_dt <= cfg_wdata;
				REG_OUTER_D: gains_q.outer_deriv_gain_dt <= cfg_wdata;
				default:     gains_q <= gains_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			drive_valid_q <= 1'b0;
		else if (ctl.emit_fire)
			drive_valid_q <= 1'b1;
		else if (drive_ready)
			drive_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_fire)
			drive_q <= result;
	end

	assign tick_ready  = ctl.in_ready;
	assign drive_valid = drive_valid_q;
	assign drive       = drive_q;

	// busy for the whole computation once a tick is taken
	a_busy_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && tick_ready |=> !tick_ready)
		else $error("tick_ready high right after a tick transfer");

	// a result comes only out of the inner loop pass
	a_emit_inner: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit_fire |-> ctl.loop_inner)
		else $error("result emitted before inner loop ran");

	// after a result is loaded the block presents it and waits for the next tick
	a_emit_then_wait: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit_fire |=> drive_valid && tick_ready)
		else $error("result not presented or sequencer not back at wait");

endmodule
